// ===== hdl/tagged_request_queue_dispatcher_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef TAGGED_REQUEST_QUEUE_DISPATCHER_UNIT_MACROS_SVH
`define TAGGED_REQUEST_QUEUE_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TRQD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define TRQD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/trqd_pkg.sv =====
package trqd_pkg;

  localparam int unsigned TagW = 6;
  localparam int unsigned OpW  = 3;
  localparam int unsigned StW  = 3;

  localparam logic [OpW-1:0] OP_ENABLE      = 3'd0;
  localparam logic [OpW-1:0] OP_DISABLE     = 3'd1;
  localparam logic [OpW-1:0] OP_SUBMIT      = 3'd2;
  localparam logic [OpW-1:0] OP_COMPLETE    = 3'd3;
  localparam logic [OpW-1:0] OP_REC_START   = 3'd4;
  localparam logic [OpW-1:0] OP_REC_FINISH  = 3'd5;
  localparam logic [OpW-1:0] OP_IDLE_QUERY  = 3'd6;

  localparam logic [StW-1:0] ST_OK          = 3'd0;
  localparam logic [StW-1:0] ST_SHUTDOWN    = 3'd1;
  localparam logic [StW-1:0] ST_BUSY        = 3'd2;
  localparam logic [StW-1:0] ST_NOT_CURRENT = 3'd3;
  localparam logic [StW-1:0] ST_NOT_IDLE    = 3'd4;

  typedef enum logic [2:0] {
    CMD_ENABLE,
    CMD_DISABLE,
    CMD_SUBMIT,
    CMD_COMPLETE,
    CMD_REC_START,
    CMD_REC_FINISH,
    CMD_IDLE_QUERY,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [TagW-1:0] tag;
  } cmd_beat_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

endpackage

// ===== hdl/trqd_front.sv =====
module trqd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [trqd_pkg::OpW-1:0]       operation,
  input  logic [trqd_pkg::TagW-1:0]      tag,
  output logic                           cmd_valid,
  output trqd_pkg::cmd_beat_t            cmd,
  input  logic                           cmd_pop
);

  trqd_pkg::cmd_beat_t fifo_q [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic [1:0]          count_next;
  logic                push;
  trqd_pkg::cmd_beat_t beat_in;

  always_comb begin
    beat_in.tag = tag;
    case (operation)
      trqd_pkg::OP_ENABLE:     beat_in.cmd = trqd_pkg::CMD_ENABLE;
      trqd_pkg::OP_DISABLE:    beat_in.cmd = trqd_pkg::CMD_DISABLE;
      trqd_pkg::OP_SUBMIT:     beat_in.cmd = trqd_pkg::CMD_SUBMIT;
      trqd_pkg::OP_COMPLETE:   beat_in.cmd = trqd_pkg::CMD_COMPLETE;
      trqd_pkg::OP_REC_START:  beat_in.cmd = trqd_pkg::CMD_REC_START;
      trqd_pkg::OP_REC_FINISH: beat_in.cmd = trqd_pkg::CMD_REC_FINISH;
      trqd_pkg::OP_IDLE_QUERY: beat_in.cmd = trqd_pkg::CMD_IDLE_QUERY;
      default:                 beat_in.cmd = trqd_pkg::CMD_NOP;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = fifo_q[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !cmd_pop) begin
      count_next = count + 2'd1;
    end else if (!push && cmd_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr] <= beat_in;
    end
  end

endmodule

// ===== hdl/trqd_back.sv =====
module trqd_back #(
  parameter int unsigned TAG_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  trqd_pkg::cmd_beat_t           cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trqd_pkg::StW-1:0]      status,
  output logic                          dispatch_valid,
  output logic [trqd_pkg::TagW-1:0]     dispatch_tag,
  output logic                          is_idle
);

  localparam int unsigned PW = $clog2(TAG_SLOTS + 1);
  localparam int unsigned IW = $clog2(TAG_SLOTS);
  localparam int unsigned WW = (PW > trqd_pkg::TagW) ? PW : trqd_pkg::TagW;
  localparam logic [PW-1:0] NoTag = PW'(TAG_SLOTS);

  trqd_pkg::bk_state_t state, state_next;

  logic          enabled, enabled_next;
  logic          halted, halted_next;
  logic          in_flight, in_flight_next;
  logic [PW-1:0] head, head_next;
  logic [PW-1:0] tail, tail_next;
  logic [PW-1:0] queued, queued_next;

  // next-tag table: data in RAM, presence in flops (absent reads as no tag)
  logic [IW-1:0]        link_mem [TAG_SLOTS];
  logic [TAG_SLOTS-1:0] link_vld;
  logic [IW-1:0]        link_rd;
  logic                 link_rd_vld;
  logic                 link_we;
  logic                 link_set;
  logic [IW-1:0]        link_addr;
  logic [IW-1:0]        link_wdata;
  logic [PW-1:0]        link_next;

  logic                        res_dv;
  logic [trqd_pkg::StW-1:0]    res_status;
  logic [trqd_pkg::TagW-1:0]   res_tag;
  logic                        res_idle;
  logic                        tag_in_range;
  logic                        tag_is_head;
  logic [PW-1:0]               tag_ptr;

  assign tag_in_range = WW'(cmd.tag) < WW'(TAG_SLOTS);
  assign tag_is_head  = WW'(cmd.tag) == WW'(head);
  assign tag_ptr      = PW'(cmd.tag);
  assign link_next    = link_rd_vld ? PW'(link_rd) : NoTag;

  always_comb begin
    state_next     = state;
    cmd_pop        = 1'b0;
    enabled_next   = enabled;
    halted_next    = halted;
    in_flight_next = in_flight;
    head_next      = head;
    tail_next      = tail;
    queued_next    = queued;
    link_we        = 1'b0;
    link_set       = 1'b0;
    link_addr      = '0;
    link_wdata     = '0;
    res_status     = trqd_pkg::ST_OK;
    res_dv         = 1'b0;
    res_tag        = '0;
    case (state)
      trqd_pkg::BK_FETCH: begin
        if (cmd_valid) begin
          state_next = trqd_pkg::BK_EXEC;
        end
      end
      trqd_pkg::BK_EXEC: begin
        if (!out_valid || out_ready) begin
          cmd_pop    = 1'b1;
          state_next = trqd_pkg::BK_FETCH;
          case (cmd.cmd)
            trqd_pkg::CMD_ENABLE: begin
              if (enabled) begin
                res_status = trqd_pkg::ST_BUSY;
              end else begin
                enabled_next = 1'b1;
              end
            end
            trqd_pkg::CMD_DISABLE: begin
              if (enabled) begin
                if ((!in_flight && queued == '0) || halted) begin
                  enabled_next = 1'b0;
                end else begin
                  res_status = trqd_pkg::ST_NOT_IDLE;
                end
              end
            end
            trqd_pkg::CMD_SUBMIT: begin
              if (!enabled) begin
                res_status = trqd_pkg::ST_SHUTDOWN;
              end else if (halted || !tag_in_range || queued >= NoTag) begin
                res_status = trqd_pkg::ST_BUSY;
              end else begin
                link_we = 1'b1;
                if (head >= NoTag) begin
                  head_next = tag_ptr;
                  tail_next = tag_ptr;
                  link_addr = IW'(cmd.tag);
                end else begin
                  link_we    = (tail < NoTag);
                  link_set   = 1'b1;
                  link_addr  = IW'(tail);
                  link_wdata = IW'(cmd.tag);
                  tail_next  = tag_ptr;
                end
                queued_next = queued + PW'(1);
                if (!in_flight && head_next < NoTag) begin
                  in_flight_next = 1'b1;
                  queued_next    = queued;
                  res_dv         = 1'b1;
                  res_tag        = trqd_pkg::TagW'(head_next);
                end
              end
            end
            trqd_pkg::CMD_COMPLETE: begin
              if (!enabled || !in_flight || !tag_is_head) begin
                res_status = trqd_pkg::ST_NOT_CURRENT;
              end else begin
                in_flight_next = 1'b0;
                if (queued == '0) begin
                  head_next = NoTag;
                  tail_next = NoTag;
                end else if (head < NoTag) begin
                  link_we   = 1'b1;
                  link_addr = IW'(head);
                  head_next = link_next;
                end
                if (!halted && queued != '0 && head_next < NoTag) begin
                  in_flight_next = 1'b1;
                  queued_next    = queued - PW'(1);
                  res_dv         = 1'b1;
                  res_tag        = trqd_pkg::TagW'(head_next);
                end
              end
            end
            trqd_pkg::CMD_REC_START: begin
              halted_next = 1'b1;
            end
            trqd_pkg::CMD_REC_FINISH: begin
              halted_next = 1'b0;
              if (queued != '0 && !in_flight && enabled && head < NoTag) begin
                in_flight_next = 1'b1;
                queued_next    = queued - PW'(1);
                res_dv         = 1'b1;
                res_tag        = trqd_pkg::TagW'(head);
              end
            end
            trqd_pkg::CMD_IDLE_QUERY: begin
              res_status = halted ? trqd_pkg::ST_BUSY : trqd_pkg::ST_OK;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = trqd_pkg::BK_FETCH;
      end
    endcase
    res_idle = (!in_flight_next && queued_next == '0) || halted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trqd_pkg::BK_FETCH;
      enabled   <= 1'b0;
      halted    <= 1'b0;
      in_flight <= 1'b0;
      head      <= NoTag;
      tail      <= NoTag;
      queued    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      enabled   <= enabled_next;
      halted    <= halted_next;
      in_flight <= in_flight_next;
      head      <= head_next;
      tail      <= tail_next;
      queued    <= queued_next;
      if (cmd_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      status         <= res_status;
      dispatch_valid <= res_dv;
      dispatch_tag   <= res_tag;
      is_idle        <= res_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld    <= '0;
      link_rd_vld <= 1'b0;
    end else begin
      link_rd_vld <= link_vld[IW'(head)];
      if (link_we) begin
        link_vld[link_addr] <= link_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[IW'(head)];
    if (link_we && link_set) begin
      link_mem[link_addr] <= link_wdata;
    end
  end

endmodule

// ===== hdl/tagged_request_queue_dispatcher_unit.sv =====
// Each input beat passes through the command queue, the back end's fetch state and its execute
//   state, which registers the result beat; the back end handles one command at a time. It reads
//   the next-tag RAM at the head in the fetch state and executes the command in the execute state.
// A two-entry command queue lets input beats land while a result waits on out_ready.
// Reset (rst, synchronous): queue disabled, not halted, nothing queued or in flight,
//   all next-tag entries empty; usable the cycle after reset drops.
module tagged_request_queue_dispatcher_unit #(
  parameter int unsigned TAG_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trqd_pkg::OpW-1:0]      operation,
  input  logic [trqd_pkg::TagW-1:0]     tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trqd_pkg::StW-1:0]      status,
  output logic                          dispatch_valid,
  output logic [trqd_pkg::TagW-1:0]     dispatch_tag,
  output logic                          is_idle
);

  logic                cmd_valid;
  logic                cmd_pop;
  trqd_pkg::cmd_beat_t cmd;

  trqd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .tag       (tag),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  trqd_back #(
    .TAG_SLOTS (TAG_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .dispatch_valid (dispatch_valid),
    .dispatch_tag   (dispatch_tag),
    .is_idle        (is_idle)
  );

endmodule

// ===== hdl/trqd_checker.sv =====
`include "tagged_request_queue_dispatcher_unit_macros.svh"

module trqd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [trqd_pkg::OpW-1:0]      operation,
  input logic [trqd_pkg::TagW-1:0]     tag,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [trqd_pkg::StW-1:0]      status,
  input logic                          dispatch_valid,
  input logic [trqd_pkg::TagW-1:0]     dispatch_tag,
  input logic                          is_idle
);

  // stalled result beat holds
  `TRQD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(dispatch_tag))
  // a dispatch only comes with an accepted command
  `TRQD_ASSERT_IMP(a_disp_ok, out_valid && dispatch_valid, status == trqd_pkg::ST_OK)
  // no dispatch means a zero tag
  `TRQD_ASSERT_IMP(a_disp_tag_zero, out_valid && !dispatch_valid, dispatch_tag == '0)
  // after a dispatch something is in flight and the queue is not halted
  `TRQD_ASSERT_IMP(a_disp_busy, out_valid && dispatch_valid, !is_idle)

endmodule

bind tagged_request_queue_dispatcher_unit trqd_checker u_trqd_checker (.*);

// ===== tb/tagged_request_queue_dispatcher_unit_tb.sv =====
`timescale 1ns / 1ps

module tagged_request_queue_dispatcher_unit_tb;

  localparam int unsigned TAG_SLOTS = 64;
  localparam bit [6:0] NO_TAG = 7'd64;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [trqd_pkg::TagW-1:0] tag_t;

  typedef struct packed {
    logic [trqd_pkg::StW-1:0]  status;
    logic                      dispatch_valid;
    logic [trqd_pkg::TagW-1:0] dispatch_tag;
    logic                      is_idle;
  } dispatch_result_t;

  class dispatch_scoreboard;
    bit enabled;
    bit halted;
    bit in_flight;
    bit [6:0] head;
    bit [6:0] tail;
    bit [6:0] queued;
    bit [6:0] links [TAG_SLOTS];
    dispatch_result_t expected_q[$];
    int errors;

    function new();
      enabled = 0;
      halted = 0;
      in_flight = 0;
      head = NO_TAG;
      tail = NO_TAG;
      queued = 0;
      foreach (links[i]) links[i] = NO_TAG;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit idle_now();
      return (!in_flight && queued == 0) || halted;
    endfunction

    function bit launch_head(output bit [trqd_pkg::TagW-1:0] sent);
      sent = '0;
      if (in_flight || halted || queued == 0 || !enabled || head >= TAG_SLOTS) return 0;
      in_flight = 1;
      queued--;
      sent = head[trqd_pkg::TagW-1:0];
      return 1;
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task note_input(trqd_pkg::cmd_t op, bit [trqd_pkg::TagW-1:0] t);
      dispatch_result_t r;
      bit [trqd_pkg::TagW-1:0] sent;
      bit sent_valid;
      bit [6:0] remains;
      bit [6:0] nxt;
      r = '0;
      r.status = trqd_pkg::ST_OK;
      sent_valid = 0;
      sent = '0;
      case (op)
        trqd_pkg::CMD_ENABLE: begin
          if (enabled) r.status = trqd_pkg::ST_BUSY;
          else enabled = 1;
        end
        trqd_pkg::CMD_DISABLE: begin
          if (enabled) begin
            if (idle_now()) enabled = 0;
            else r.status = trqd_pkg::ST_NOT_IDLE;
          end
        end
        trqd_pkg::CMD_SUBMIT: begin
          if (!enabled) begin
            r.status = trqd_pkg::ST_SHUTDOWN;
          end else if (halted || {1'b0, t} >= TAG_SLOTS
                       || queued >= TAG_SLOTS) begin
            r.status = trqd_pkg::ST_BUSY;
          end else begin
            if (head >= TAG_SLOTS) begin
              head = {1'b0, t};
              tail = {1'b0, t};
              links[t] = NO_TAG;
            end else begin
              if (tail < TAG_SLOTS) links[tail[trqd_pkg::TagW-1:0]] = {1'b0, t};
              tail = {1'b0, t};
            end
            queued++;
            sent_valid = launch_head(sent);
          end
        end
        trqd_pkg::CMD_COMPLETE: begin
          if (!enabled || !in_flight || {1'b0, t} != head) begin
            r.status = trqd_pkg::ST_NOT_CURRENT;
          end else begin
            remains = queued;
            in_flight = 0;
            if (remains == 0) begin
              head = NO_TAG;
              tail = NO_TAG;
            end else if (head < TAG_SLOTS) begin
              nxt = links[head[trqd_pkg::TagW-1:0]];
              links[head[trqd_pkg::TagW-1:0]] = NO_TAG;
              head = nxt;
            end
            if (!halted && remains > 0) sent_valid = launch_head(sent);
          end
        end
        trqd_pkg::CMD_REC_START: halted = 1;
        trqd_pkg::CMD_REC_FINISH: begin
          halted = 0;
          if (queued > 0) sent_valid = launch_head(sent);
        end
        trqd_pkg::CMD_IDLE_QUERY: r.status = halted ? trqd_pkg::ST_BUSY : trqd_pkg::ST_OK;
        default: ;
      endcase
      r.dispatch_valid = sent_valid;
      r.dispatch_tag = sent_valid ? sent : '0;
      r.is_idle = idle_now();
      expected_q.push_back(r);
    endtask

    task check_result(dispatch_result_t got);
      dispatch_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result beat st=%0d dv=%0d dt=%0d idle=%0d",
                         got.status, got.dispatch_valid, got.dispatch_tag, got.is_idle));
      end else begin
        e = expected_q.pop_front();
        if (got.status !== e.status || got.dispatch_valid !== e.dispatch_valid ||
            got.dispatch_tag !== e.dispatch_tag || got.is_idle !== e.is_idle)
          report($sformatf({"result mismatch: exp st=%0d dv=%0d dt=%0d idle=%0d,",
                            " got st=%0d dv=%0d dt=%0d idle=%0d"},
                           e.status, e.dispatch_valid, e.dispatch_tag, e.is_idle,
                           got.status, got.dispatch_valid, got.dispatch_tag, got.is_idle));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [trqd_pkg::OpW-1:0]  operation = '0;
  logic [trqd_pkg::TagW-1:0] tag = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [trqd_pkg::StW-1:0]  status;
  logic                      dispatch_valid;
  logic [trqd_pkg::TagW-1:0] dispatch_tag;
  logic                      is_idle;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  dispatch_scoreboard sb = new();

  tagged_request_queue_dispatcher_unit #(.TAG_SLOTS(TAG_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .tag(tag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .dispatch_valid(dispatch_valid),
    .dispatch_tag(dispatch_tag),
    .is_idle(is_idle)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({status, dispatch_valid, dispatch_tag, is_idle});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one input beat; the predictor is updated at the accepting edge
  task send_item(trqd_pkg::cmd_t op, bit [trqd_pkg::TagW-1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    tag <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, t);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // push past a full queue, then retire everything in order
  task fill_and_drain();
    bit [trqd_pkg::TagW-1:0] base;
    base = tag_t'($urandom_range(0, 63));
    if (!sb.enabled) send_item(trqd_pkg::CMD_ENABLE, tag_t'($urandom_range(0, 63)));
    if (sb.halted) send_item(trqd_pkg::CMD_REC_FINISH, tag_t'($urandom_range(0, 63)));
    for (int i = 0; i < 67; i++)
      send_item(trqd_pkg::CMD_SUBMIT, base + i[trqd_pkg::TagW-1:0]);
    while (sb.in_flight) send_item(trqd_pkg::CMD_COMPLETE, sb.head[trqd_pkg::TagW-1:0]);
  endtask

  task random_item(output bit counted);
    int r;
    trqd_pkg::cmd_t op;
    bit [trqd_pkg::TagW-1:0] t;
    t = tag_t'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (!sb.enabled && r < 50) begin
      op = trqd_pkg::CMD_ENABLE;
    end else if (sb.halted && r < 40) begin
      op = trqd_pkg::CMD_REC_FINISH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        op = trqd_pkg::CMD_SUBMIT;
      end else if (r < 70) begin
        op = trqd_pkg::CMD_COMPLETE;
        if (sb.in_flight && $urandom_range(0, 99) < 80) t = sb.head[trqd_pkg::TagW-1:0];
      end else if (r < 76) op = trqd_pkg::CMD_ENABLE;
      else if (r < 82) op = trqd_pkg::CMD_DISABLE;
      else if (r < 87) op = trqd_pkg::CMD_REC_START;
      else if (r < 92) op = trqd_pkg::CMD_REC_FINISH;
      else if (r < 98) op = trqd_pkg::CMD_IDLE_QUERY;
      else op = trqd_pkg::CMD_NOP;
    end
    send_item(op, t);
    counted = (op != trqd_pkg::CMD_NOP);
  endtask

  task random_run(int n);
    int done_cnt;
    bit counted;
    done_cnt = 0;
    while (done_cnt < n) begin
      random_item(counted);
      if (counted) done_cnt++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: disabled queue, enable rules, halt and resume, resubmitted tag
    send_item(trqd_pkg::CMD_IDLE_QUERY, 6'd0);
    send_item(trqd_pkg::CMD_SUBMIT, 6'd5);
    send_item(trqd_pkg::CMD_COMPLETE, 6'd0);
    send_item(trqd_pkg::CMD_DISABLE, 6'd0);
    send_item(trqd_pkg::CMD_NOP, 6'd63);
    send_item(trqd_pkg::CMD_ENABLE, 6'd0);
    send_item(trqd_pkg::CMD_ENABLE, 6'd0);
    send_item(trqd_pkg::CMD_SUBMIT, 6'd0);
    send_item(trqd_pkg::CMD_SUBMIT, 6'd63);
    send_item(trqd_pkg::CMD_SUBMIT, 6'd42);
    send_item(trqd_pkg::CMD_DISABLE, 6'd0);
    send_item(trqd_pkg::CMD_COMPLETE, 6'd63);
    send_item(trqd_pkg::CMD_REC_START, 6'd0);
    send_item(trqd_pkg::CMD_SUBMIT, 6'd21);
    send_item(trqd_pkg::CMD_IDLE_QUERY, 6'd0);
    send_item(trqd_pkg::CMD_COMPLETE, 6'd0);
    send_item(trqd_pkg::CMD_REC_FINISH, 6'd0);
    send_item(trqd_pkg::CMD_COMPLETE, 6'd63);
    send_item(trqd_pkg::CMD_SUBMIT, 6'd42);
    send_item(trqd_pkg::CMD_COMPLETE, 6'd42);
    send_item(trqd_pkg::CMD_COMPLETE, 6'd42);
    send_item(trqd_pkg::CMD_REC_START, 6'd0);
    send_item(trqd_pkg::CMD_DISABLE, 6'd0);
    send_item(trqd_pkg::CMD_REC_FINISH, 6'd0);
    send_item(trqd_pkg::CMD_ENABLE, 6'd0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      fill_and_drain();
      random_run(90);
      wait_drained();
      random_run(90);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/trqd_pkg.sv
hdl/trqd_front.sv
hdl/trqd_back.sv
hdl/tagged_request_queue_dispatcher_unit.sv
hdl/trqd_checker.sv
tb/tagged_request_queue_dispatcher_unit_tb.sv
